// ===== design/ptf_pkg.sv =====
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared sizes, codes and types for the programmable table state machine.
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam int MAX_STATES      = 16;
  localparam int MAX_TRANSITIONS = 8;
  localparam int SYMBOL_BITS     = 8;

  localparam int STATE_BITS = $clog2(MAX_STATES);
  localparam int NUM_BITS   = $clog2(MAX_STATES + 1);
  localparam int LANE_BITS  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int COUNT_BITS = $clog2(MAX_TRANSITIONS + 1);
  localparam int CMD_BITS   = 3;
  localparam int STAT_BITS  = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INIT       = 3'd0,
    CMD_ADD_TRANS  = 3'd1,
    CMD_SET_DFLT   = 3'd2,
    CMD_MARK_FINAL = 3'd3,
    CMD_MARK_ERROR = 3'd4,
    CMD_STEP       = 3'd5
  } cmd_code_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_STATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic [STATE_BITS-1:0]  target;
  } trans_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// ===== design/ptf_if.sv =====
// ----------------------------------------------------------------------------
// ptf_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ptf_in_if;
  logic                             valid;
  logic                             ready;
  logic [ptf_pkg::CMD_BITS-1:0]     command;
  logic [ptf_pkg::STATE_BITS-1:0]   from_state;
  logic [ptf_pkg::STATE_BITS-1:0]   to_state;
  logic [ptf_pkg::SYMBOL_BITS-1:0]  symbol;

  modport source (output valid, command, from_state, to_state, symbol, input ready);
  modport sink (input valid, command, from_state, to_state, symbol, output ready);
endinterface

interface ptf_out_if;
  logic                            valid;
  logic                            ready;
  logic [ptf_pkg::STAT_BITS-1:0]   status;
  logic                            matched;
  logic [ptf_pkg::STATE_BITS-1:0]  current_state;
  logic [ptf_pkg::STATE_BITS-1:0]  previous_state;
  logic                            in_error;
  logic                            accepted;

  modport source (output valid, status, matched, current_state, previous_state, in_error,
                  accepted, input ready);
  modport sink (input valid, status, matched, current_state, previous_state, in_error,
                accepted, output ready);
endinterface

// ===== design/ptf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptf_ctrl
// Sequencer: captures one transaction, executes it, holds the result register.
// ----------------------------------------------------------------------------
module ptf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ptf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // result register must be free or draining this cycle
  assign cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.capture) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.execute) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("captured transaction did not move to execute");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("executed transaction produced no result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && out_valid && !out_ready) |=> state == S_EXEC && !cmd.capture)
    else $error("execute left while result register was blocked");
`endif

endmodule

// ===== design/ptf_datapath.sv =====
// ----------------------------------------------------------------------------
// ptf_datapath
// State table, transition row memory, item and result registers.
// ----------------------------------------------------------------------------
module ptf_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ptf_pkg::NUM_BITS-1:0]     cfg_wdata,
  input  ptf_pkg::dp_cmd_t                 cmd,
  input  logic [ptf_pkg::CMD_BITS-1:0]     command,
  input  logic [ptf_pkg::STATE_BITS-1:0]   from_state,
  input  logic [ptf_pkg::STATE_BITS-1:0]   to_state,
  input  logic [ptf_pkg::SYMBOL_BITS-1:0]  symbol,
  output logic [ptf_pkg::STAT_BITS-1:0]    res_status,
  output logic                             res_matched,
  output logic [ptf_pkg::STATE_BITS-1:0]   res_current,
  output logic [ptf_pkg::STATE_BITS-1:0]   res_previous,
  output logic                             res_in_error,
  output logic                             res_accepted
);

  logic [ptf_pkg::NUM_BITS-1:0]    num_states;
  logic [ptf_pkg::STATE_BITS-1:0]  cur_state;
  logic [ptf_pkg::STATE_BITS-1:0]  prev_state;
  logic [ptf_pkg::STATE_BITS-1:0]  err_state;
  logic [ptf_pkg::COUNT_BITS-1:0]  trans_count [ptf_pkg::MAX_STATES];
  logic [ptf_pkg::STATE_BITS-1:0]  dflt_target [ptf_pkg::MAX_STATES];
  logic [ptf_pkg::MAX_STATES-1:0]  final_flags;

  // captured item
  logic [ptf_pkg::CMD_BITS-1:0]    cmd_q;
  logic [ptf_pkg::STATE_BITS-1:0]  from_q;
  logic [ptf_pkg::STATE_BITS-1:0]  to_q;
  logic [ptf_pkg::SYMBOL_BITS-1:0] sym_q;

  // one row per state, one lane per transition slot
  ptf_pkg::trans_entry_t trans_mem [ptf_pkg::MAX_STATES][ptf_pkg::MAX_TRANSITIONS];
  ptf_pkg::trans_entry_t row_q [ptf_pkg::MAX_TRANSITIONS];

  logic [ptf_pkg::STATE_BITS-1:0]  last_idx;
  logic                            from_ok;
  logic                            to_ok;
  logic [ptf_pkg::STATE_BITS-1:0]  cnt_addr;
  logic [ptf_pkg::COUNT_BITS-1:0]  cnt_sel;
  logic                            list_full;
  logic                            mem_we;
  logic                            cnt_inc;
  logic                            step_hit;
  logic [ptf_pkg::STATE_BITS-1:0]  step_target;
  logic [ptf_pkg::STATE_BITS-1:0]  cur_next;
  logic [ptf_pkg::STATE_BITS-1:0]  prev_next;
  logic [ptf_pkg::STATE_BITS-1:0]  err_next;
  logic [ptf_pkg::MAX_STATES-1:0]  final_next;
  logic [ptf_pkg::STAT_BITS-1:0]   status_next;
  logic                            matched_next;

  // clamp count to 1..MAX_STATES, keep the last valid index
  always_comb begin
    if (num_states == '0) begin
      last_idx = '0;
    end else if (num_states > ptf_pkg::NUM_BITS'(ptf_pkg::MAX_STATES)) begin
      last_idx = ptf_pkg::STATE_BITS'(ptf_pkg::MAX_STATES - 1);
    end else begin
      last_idx = ptf_pkg::STATE_BITS'(num_states - 1'b1);
    end
  end

  assign from_ok   = (from_q <= last_idx);
  assign to_ok     = (to_q <= last_idx);
  assign cnt_addr  = (cmd_q == ptf_pkg::CMD_STEP) ? cur_state : from_q;
  assign cnt_sel   = trans_count[cnt_addr];
  assign list_full = (cnt_sel >= ptf_pkg::COUNT_BITS'(ptf_pkg::MAX_TRANSITIONS));

  // first matching lane below the count wins
  always_comb begin
    step_hit    = 1'b0;
    step_target = dflt_target[cur_state];
    for (int i = 0; i < ptf_pkg::MAX_TRANSITIONS; i++) begin
      if (!step_hit && (ptf_pkg::COUNT_BITS'(i) < cnt_sel) &&
          (row_q[i].symbol == sym_q)) begin
        step_hit    = 1'b1;
        step_target = row_q[i].target;
      end
    end
  end

  always_comb begin
    cur_next     = cur_state;
    prev_next    = prev_state;
    err_next     = err_state;
    final_next   = final_flags;
    status_next  = ptf_pkg::ST_OK;
    matched_next = 1'b0;
    mem_we       = 1'b0;
    cnt_inc      = 1'b0;
    case (cmd_q)
      ptf_pkg::CMD_INIT: begin
        cur_next   = '0;
        prev_next  = '0;
        err_next   = last_idx;
        final_next = '0;
      end
      ptf_pkg::CMD_ADD_TRANS: begin
        if (!from_ok || !to_ok) begin
          status_next = ptf_pkg::ST_BAD_STATE;
        end else if (list_full) begin
          status_next = ptf_pkg::ST_FULL;
        end else begin
          mem_we  = cmd.execute;
          cnt_inc = 1'b1;
        end
      end
      ptf_pkg::CMD_SET_DFLT: begin
        if (!from_ok || !to_ok) status_next = ptf_pkg::ST_BAD_STATE;
      end
      ptf_pkg::CMD_MARK_FINAL: begin
        if (!from_ok) status_next = ptf_pkg::ST_BAD_STATE;
        else final_next[from_q] = 1'b1;
      end
      ptf_pkg::CMD_MARK_ERROR: begin
        if (!from_ok) begin
          status_next = ptf_pkg::ST_BAD_STATE;
        end else begin
          err_next            = from_q;
          final_next[from_q]  = 1'b0;
        end
      end
      ptf_pkg::CMD_STEP: begin
        prev_next    = cur_state;
        cur_next     = step_target;
        matched_next = step_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= command;
      from_q <= from_state;
      to_q   <= to_state;
      sym_q  <= symbol;
    end
    if (cmd.execute) begin
      res_status   <= status_next;
      res_matched  <= matched_next;
      res_current  <= cur_next;
      res_previous <= prev_next;
      res_in_error <= (cur_next == err_next);
      res_accepted <= final_next[cur_next];
    end
  end

  // transition rows: single-lane write, full-row registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      trans_mem[from_q][cnt_sel[ptf_pkg::LANE_BITS-1:0]] <= '{symbol: sym_q, target: to_q};
    end
    if (cmd.capture) begin
      row_q <= trans_mem[cur_state];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= ptf_pkg::NUM_BITS'(ptf_pkg::MAX_STATES);
      cur_state   <= '0;
      prev_state  <= '0;
      err_state   <= ptf_pkg::STATE_BITS'(ptf_pkg::MAX_STATES - 1);
      final_flags <= '0;
      for (int i = 0; i < ptf_pkg::MAX_STATES; i++) begin
        trans_count[i] <= '0;
        dflt_target[i] <= ptf_pkg::STATE_BITS'(ptf_pkg::MAX_STATES - 1);
      end
    end else begin
      if (cfg_we) num_states <= cfg_wdata;
      if (cmd.execute) begin
        cur_state   <= cur_next;
        prev_state  <= prev_next;
        err_state   <= err_next;
        final_flags <= final_next;
        case (cmd_q)
          ptf_pkg::CMD_INIT: begin
            for (int i = 0; i < ptf_pkg::MAX_STATES; i++) begin
              trans_count[i] <= '0;
              dflt_target[i] <= last_idx;
            end
          end
          ptf_pkg::CMD_ADD_TRANS: begin
            if (cnt_inc) trans_count[from_q] <= ptf_pkg::COUNT_BITS'(cnt_sel + 1'b1);
          end
          ptf_pkg::CMD_SET_DFLT: begin
            if (from_ok && to_ok) dflt_target[from_q] <= to_q;
          end
          ptf_pkg::CMD_MARK_ERROR: begin
            if (from_ok) begin
              trans_count[from_q] <= '0;
              dflt_target[from_q] <= from_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    trans_count[cur_state] <= ptf_pkg::COUNT_BITS'(ptf_pkg::MAX_TRANSITIONS))
    else $error("transition count above list size");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && cmd_q == ptf_pkg::CMD_INIT) |=>
      (cur_state == '0 && prev_state == '0 && final_flags == '0))
    else $error("init left state behind");

  a_error_loop: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && cmd_q == ptf_pkg::CMD_MARK_ERROR && from_ok) |=>
      (dflt_target[err_state] == err_state && trans_count[err_state] == '0))
    else $error("error state does not loop on itself");
`endif

endmodule

// ===== design/programmable_table_fsm_core.sv =====
// ----------------------------------------------------------------------------
// programmable_table_fsm_core
// Table-driven state machine built and stepped by command transactions.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result. A transaction has a
// capture cycle, which also reads the current state's transition row (all
// slots at once) from the row memory, and an execute cycle, which compares
// the symbol against every slot, applies the command and loads the result
// register. The next transaction is accepted in the cycle after execute, so
// no new transaction is taken before the previous one has executed;
// execute waits as long as the previous result is still held. Table memory is
// not cleared on reset; per-state counts keep unwritten slots from being read.
// num_states may be written only while no transaction is in flight.
module programmable_table_fsm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ptf_pkg::NUM_BITS-1:0]  cfg_wdata,
  ptf_in_if.sink                        item,
  ptf_out_if.source                     result
);

  ptf_pkg::dp_cmd_t dp_cmd;

  ptf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (dp_cmd)
  );

  ptf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (dp_cmd),
    .command      (item.command),
    .from_state   (item.from_state),
    .to_state     (item.to_state),
    .symbol       (item.symbol),
    .res_status   (result.status),
    .res_matched  (result.matched),
    .res_current  (result.current_state),
    .res_previous (result.previous_state),
    .res_in_error (result.in_error),
    .res_accepted (result.accepted)
  );

endmodule
